// ===== sv/qef_pkg.sv =====
`default_nettype none

package qef_pkg;

	// filter lengths
	localparam int LP_LEN    = 10;
	localparam int HP_LEN    = 25;
	localparam int SLOPE_LEN = 2;
	localparam int WIN_LEN   = 16;

	// payload widths and output limit
	localparam int X_W        = 16;
	localparam int ENERGY_W   = 15;
	localparam int ENERGY_MAX = 32000;

	// low-pass: recursion width, divisor and reciprocal for the divide
	localparam int LP_Y_W = X_W + $clog2(LP_LEN * LP_LEN) + 1;
	localparam int LP_DIV = (LP_LEN * LP_LEN) / 4;
	localparam int LP_K   = LP_Y_W + $clog2(LP_DIV);
	localparam logic [LP_K:0] LP_M =
		(LP_K + 1)'(((64'd1 << LP_K) + 64'(LP_DIV) - 64'd1) / 64'(LP_DIV));
	localparam int LP_O_W = X_W + 3;

	// high-pass: running sum width and reciprocal of the window length
	localparam int HP_SUM_W = LP_O_W + $clog2(HP_LEN);
	localparam int HP_K     = HP_SUM_W + $clog2(HP_LEN);
	localparam logic [HP_K:0] HP_M =
		(HP_K + 1)'(((64'd1 << HP_K) + 64'(HP_LEN) - 64'd1) / 64'(HP_LEN));
	localparam int HP_O_W   = LP_O_W + 1;

	// slope, magnitude and integration window
	localparam int SL_W      = HP_O_W + 1;
	localparam int ABS_W     = SL_W - 1;
	localparam int WIN_SUM_W = ABS_W + $clog2(WIN_LEN);
	localparam int WIN_K     = WIN_SUM_W + $clog2(WIN_LEN);
	localparam logic [WIN_K:0] WIN_M =
		(WIN_K + 1)'(((64'd1 << WIN_K) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN));

	// control that travels with each beat down the pipeline
	typedef struct packed {
		logic vld;
		logic restart;
	} qef_ctl_t;

endpackage

`default_nettype wire

// ===== sv/qef_lowpass.sv =====
`default_nettype none

module qef_lowpass (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire qef_pkg::qef_ctl_t                  in_ctl,
	input  wire logic signed [qef_pkg::X_W-1:0]     in_x,
	output logic                                    in_rdy,
	output qef_pkg::qef_ctl_t                       out_ctl,
	output logic signed [qef_pkg::LP_O_W-1:0]       out_y,
	input  wire                                     out_rdy
);

	// filter state
	logic signed [qef_pkg::X_W-1:0]    lp_hist_q [qef_pkg::LP_LEN];
	logic signed [qef_pkg::LP_Y_W-1:0] lp_prev1_q;
	logic signed [qef_pkg::LP_Y_W-1:0] lp_prev2_q;

	// pipeline registers
	qef_pkg::qef_ctl_t                  ctl_s2, ctl_s3, ctl_s4;
	logic signed [qef_pkg::LP_Y_W-1:0]  y_s2;
	logic [qef_pkg::LP_Y_W+qef_pkg::LP_K:0] prod_s3;
	logic                               neg_s3;
	logic signed [qef_pkg::LP_O_W-1:0]  y_s4;

	logic rdy_s2, rdy_s3, rdy_s4, fire;
	logic signed [qef_pkg::LP_Y_W-1:0] p1_eff, p2_eff, half_eff, old_eff, y_next;
	logic [qef_pkg::LP_Y_W-1:0]        y_mag;
	logic [qef_pkg::LP_O_W-1:0]        q_mag;

	// ready ripples back from the output
	assign rdy_s4 = !ctl_s4.vld || out_rdy;
	assign rdy_s3 = !ctl_s3.vld || rdy_s4;
	assign rdy_s2 = !ctl_s2.vld || rdy_s3;
	assign in_rdy = rdy_s2;
	assign fire   = in_ctl.vld && rdy_s2;

	// double-integrator recursion, restart sees cleared state
	always_comb begin
		p1_eff   = in_ctl.restart ? '0 : lp_prev1_q;
		p2_eff   = in_ctl.restart ? '0 : lp_prev2_q;
		half_eff = in_ctl.restart ? '0 :
			qef_pkg::LP_Y_W'(lp_hist_q[qef_pkg::LP_LEN/2 - 1]);
		old_eff  = in_ctl.restart ? '0 :
			qef_pkg::LP_Y_W'(lp_hist_q[qef_pkg::LP_LEN - 1]);
		y_next   = (p1_eff <<< 1) - p2_eff + qef_pkg::LP_Y_W'(in_x)
			- (half_eff <<< 1) + old_eff;
	end

	// state update, history is a shift line (tap 0 is the newest)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qef_pkg::LP_LEN; i++) lp_hist_q[i] <= '0;
			lp_prev1_q <= '0;
			lp_prev2_q <= '0;
		end else if (fire) begin
			lp_hist_q[0] <= in_x;
			for (int i = 1; i < qef_pkg::LP_LEN; i++)
				lp_hist_q[i] <= in_ctl.restart ? '0 : lp_hist_q[i-1];
			lp_prev1_q <= y_next;
			lp_prev2_q <= p1_eff;
		end
	end

	// truncating divide by reciprocal multiply on the magnitude
	assign y_mag = y_s2[qef_pkg::LP_Y_W-1] ? $unsigned(-y_s2) : $unsigned(y_s2);
	assign q_mag = prod_s3[qef_pkg::LP_K +: qef_pkg::LP_O_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			if (rdy_s2) ctl_s2 <= in_ctl;
			if (rdy_s3) ctl_s3 <= ctl_s2;
			if (rdy_s4) ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) y_s2 <= y_next;
		if (rdy_s3 && ctl_s2.vld) begin
			prod_s3 <= y_mag * qef_pkg::LP_M;
			neg_s3  <= y_s2[qef_pkg::LP_Y_W-1];
		end
		if (rdy_s4 && ctl_s3.vld)
			y_s4 <= neg_s3 ? -$signed(q_mag) : $signed(q_mag);
	end

	assign out_ctl = ctl_s4;
	assign out_y   = y_s4;

endmodule

`default_nettype wire

// ===== sv/qef_highpass.sv =====
`default_nettype none

module qef_highpass (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire qef_pkg::qef_ctl_t                  in_ctl,
	input  wire logic signed [qef_pkg::LP_O_W-1:0]  in_x,
	output logic                                    in_rdy,
	output qef_pkg::qef_ctl_t                       out_ctl,
	output logic signed [qef_pkg::HP_O_W-1:0]       out_z,
	input  wire                                     out_rdy
);

	// filter state
	logic signed [qef_pkg::LP_O_W-1:0]   hp_hist_q [qef_pkg::HP_LEN];
	logic signed [qef_pkg::HP_SUM_W-1:0] hp_sum_q;

	// pipeline registers
	qef_pkg::qef_ctl_t                    ctl_s5, ctl_s6, ctl_s7;
	logic signed [qef_pkg::HP_SUM_W-1:0]  sum_s5;
	logic signed [qef_pkg::LP_O_W-1:0]    mid_s5, mid_s6;
	logic [qef_pkg::HP_SUM_W+qef_pkg::HP_K:0] prod_s6;
	logic                                 neg_s6;
	logic signed [qef_pkg::HP_O_W-1:0]    z_s7;

	logic rdy_s5, rdy_s6, rdy_s7, fire;
	logic signed [qef_pkg::HP_SUM_W-1:0] sum_eff, old_eff, sum_next;
	logic signed [qef_pkg::LP_O_W-1:0]   mid_eff;
	logic [qef_pkg::HP_SUM_W-1:0]        sum_mag;
	logic [qef_pkg::LP_O_W-1:0]          q_mag;
	logic signed [qef_pkg::HP_O_W-1:0]   mid_ext, q_ext;

	assign rdy_s7 = !ctl_s7.vld || out_rdy;
	assign rdy_s6 = !ctl_s6.vld || rdy_s7;
	assign rdy_s5 = !ctl_s5.vld || rdy_s6;
	assign in_rdy = rdy_s5;
	assign fire   = in_ctl.vld && rdy_s5;

	// running sum over the window and the center tap
	always_comb begin
		sum_eff  = in_ctl.restart ? '0 : hp_sum_q;
		old_eff  = in_ctl.restart ? '0 :
			qef_pkg::HP_SUM_W'(hp_hist_q[qef_pkg::HP_LEN - 1]);
		mid_eff  = in_ctl.restart ? '0 : hp_hist_q[qef_pkg::HP_LEN/2 - 1];
		sum_next = sum_eff + qef_pkg::HP_SUM_W'(in_x) - old_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qef_pkg::HP_LEN; i++) hp_hist_q[i] <= '0;
			hp_sum_q <= '0;
		end else if (fire) begin
			hp_hist_q[0] <= in_x;
			for (int i = 1; i < qef_pkg::HP_LEN; i++)
				hp_hist_q[i] <= in_ctl.restart ? '0 : hp_hist_q[i-1];
			hp_sum_q <= sum_next;
		end
	end

	// mean by reciprocal multiply, then subtract from the center tap
	assign sum_mag = sum_s5[qef_pkg::HP_SUM_W-1] ? $unsigned(-sum_s5) : $unsigned(sum_s5);
	assign q_mag   = prod_s6[qef_pkg::HP_K +: qef_pkg::LP_O_W];
	assign mid_ext = qef_pkg::HP_O_W'(mid_s6);
	assign q_ext   = $signed({1'b0, q_mag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			if (rdy_s5) ctl_s5 <= in_ctl;
			if (rdy_s6) ctl_s6 <= ctl_s5;
			if (rdy_s7) ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sum_s5 <= sum_next;
			mid_s5 <= mid_eff;
		end
		if (rdy_s6 && ctl_s5.vld) begin
			prod_s6 <= sum_mag * qef_pkg::HP_M;
			neg_s6  <= sum_s5[qef_pkg::HP_SUM_W-1];
			mid_s6  <= mid_s5;
		end
		if (rdy_s7 && ctl_s6.vld)
			z_s7 <= neg_s6 ? (mid_ext + q_ext) : (mid_ext - q_ext);
	end

	assign out_ctl = ctl_s7;
	assign out_z   = z_s7;

endmodule

`default_nettype wire

// ===== sv/qef_energy.sv =====
`default_nettype none

module qef_energy (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire qef_pkg::qef_ctl_t                  in_ctl,
	input  wire logic signed [qef_pkg::HP_O_W-1:0]  in_x,
	output logic                                    in_rdy,
	output logic                                    out_vld,
	output logic [qef_pkg::ENERGY_W-1:0]            out_energy,
	input  wire                                     out_rdy
);

	// slope and window state
	logic signed [qef_pkg::HP_O_W-1:0] sl_hist_q [qef_pkg::SLOPE_LEN];
	logic [qef_pkg::ABS_W-1:0]         win_hist_q [qef_pkg::WIN_LEN];
	logic [qef_pkg::WIN_SUM_W-1:0]     win_sum_q;

	// pipeline registers
	qef_pkg::qef_ctl_t                ctl_s8, ctl_s9, ctl_s10, ctl_s11;
	logic [qef_pkg::ABS_W-1:0]        abs_s8;
	logic [qef_pkg::WIN_SUM_W-1:0]    wsum_s9;
	logic [qef_pkg::WIN_SUM_W+qef_pkg::WIN_K:0] prod_s10;
	logic [qef_pkg::ENERGY_W-1:0]     energy_s11;

	logic rdy_s8, rdy_s9, rdy_s10, rdy_s11, fire, fire_s9;
	logic signed [qef_pkg::SL_W-1:0]  sl_old, slope;
	logic [qef_pkg::ABS_W-1:0]        slope_abs;
	logic [qef_pkg::WIN_SUM_W-1:0]    wsum_eff, wold_eff, wsum_next, avg;

	assign rdy_s11 = !ctl_s11.vld || out_rdy;
	assign rdy_s10 = !ctl_s10.vld || rdy_s11;
	assign rdy_s9  = !ctl_s9.vld || rdy_s10;
	assign rdy_s8  = !ctl_s8.vld || rdy_s9;
	assign in_rdy  = rdy_s8;
	assign fire    = in_ctl.vld && rdy_s8;
	assign fire_s9 = ctl_s8.vld && rdy_s9;

	// slope against the delayed sample, then magnitude
	always_comb begin
		sl_old    = in_ctl.restart ? '0 :
			qef_pkg::SL_W'(sl_hist_q[qef_pkg::SLOPE_LEN - 1]);
		slope     = qef_pkg::SL_W'(in_x) - sl_old;
		slope_abs = slope[qef_pkg::SL_W-1] ? qef_pkg::ABS_W'(-slope)
			: qef_pkg::ABS_W'(slope);
	end

	// moving window sum, never negative
	always_comb begin
		wsum_eff  = ctl_s8.restart ? '0 : win_sum_q;
		wold_eff  = ctl_s8.restart ? '0 :
			qef_pkg::WIN_SUM_W'(win_hist_q[qef_pkg::WIN_LEN - 1]);
		wsum_next = wsum_eff + qef_pkg::WIN_SUM_W'(abs_s8) - wold_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qef_pkg::SLOPE_LEN; i++) sl_hist_q[i] <= '0;
			for (int i = 0; i < qef_pkg::WIN_LEN; i++) win_hist_q[i] <= '0;
			win_sum_q <= '0;
		end else begin
			if (fire) begin
				sl_hist_q[0] <= in_x;
				for (int i = 1; i < qef_pkg::SLOPE_LEN; i++)
					sl_hist_q[i] <= in_ctl.restart ? '0 : sl_hist_q[i-1];
			end
			if (fire_s9) begin
				win_hist_q[0] <= abs_s8;
				for (int i = 1; i < qef_pkg::WIN_LEN; i++)
					win_hist_q[i] <= ctl_s8.restart ? '0 : win_hist_q[i-1];
				win_sum_q <= wsum_next;
			end
		end
	end

	// average by reciprocal multiply and clamp
	assign avg = prod_s10[qef_pkg::WIN_K +: qef_pkg::WIN_SUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
		end else begin
			if (rdy_s8)  ctl_s8  <= in_ctl;
			if (rdy_s9)  ctl_s9  <= ctl_s8;
			if (rdy_s10) ctl_s10 <= ctl_s9;
			if (rdy_s11) ctl_s11 <= ctl_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) abs_s8 <= slope_abs;
		if (fire_s9) wsum_s9 <= wsum_next;
		if (rdy_s10 && ctl_s9.vld) prod_s10 <= wsum_s9 * qef_pkg::WIN_M;
		if (rdy_s11 && ctl_s10.vld) begin
			if (avg > qef_pkg::WIN_SUM_W'(qef_pkg::ENERGY_MAX))
				energy_s11 <= qef_pkg::ENERGY_W'(qef_pkg::ENERGY_MAX);
			else
				energy_s11 <= avg[qef_pkg::ENERGY_W-1:0];
		end
	end

	assign out_vld    = ctl_s11.vld;
	assign out_energy = energy_s11;

endmodule

`default_nettype wire

// ===== sv/qrs_energy_filter_chain_unit.sv =====
`default_nettype none

// QRS energy filter chain: one signed 16-bit ECG sample in, one energy value
// (0 to 32000) out per beat, through low-pass, high-pass, slope, magnitude and
// moving-window integration. The block is an eleven-register pipeline, and a
// new sample is taken every cycle while the output is drained; each filter's
// recursion closes within one register stage, which is what holds the rate at
// one beat per cycle. A sample with restart set clears all filter history
// before it is filtered and still gives one result. Backpressure on the output
// fills the pipeline bubbles first and then stalls the input.
module qrs_energy_filter_chain_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire logic signed [qef_pkg::X_W-1:0]   sample,
	input  wire                                   restart,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [qef_pkg::ENERGY_W-1:0]          energy
);

	qef_pkg::qef_ctl_t                  ctl_s1, lp_ctl, hp_ctl;
	logic signed [qef_pkg::X_W-1:0]     sample_s1;
	logic signed [qef_pkg::LP_O_W-1:0]  lp_y;
	logic signed [qef_pkg::HP_O_W-1:0]  hp_z;
	logic                               lp_in_rdy, hp_in_rdy, en_in_rdy;

	// input register
	assign in_ready = !ctl_s1.vld || lp_in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_ready) begin
			ctl_s1.vld     <= in_valid;
			ctl_s1.restart <= restart;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) sample_s1 <= sample;
	end

	// filter stages
	qef_lowpass u_lowpass (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s1),
		.in_x    (sample_s1),
		.in_rdy  (lp_in_rdy),
		.out_ctl (lp_ctl),
		.out_y   (lp_y),
		.out_rdy (hp_in_rdy)
	);

	qef_highpass u_highpass (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (lp_ctl),
		.in_x    (lp_y),
		.in_rdy  (hp_in_rdy),
		.out_ctl (hp_ctl),
		.out_z   (hp_z),
		.out_rdy (en_in_rdy)
	);

	qef_energy u_energy (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ctl     (hp_ctl),
		.in_x       (hp_z),
		.in_rdy     (en_in_rdy),
		.out_vld    (out_valid),
		.out_energy (energy),
		.out_rdy    (out_ready)
	);

`ifndef SYNTHESIS
	// result is always within the clamp
	a_energy_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> energy <= qef_pkg::ENERGY_W'(qef_pkg::ENERGY_MAX))
		else $error("energy above clamp");

	// a free output leaves the whole pipeline open to input
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input blocked while output drains");

	// a held input-stage beat keeps its sample
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.vld && !lp_in_rdy) |=> (ctl_s1.vld && $stable(sample_s1)))
		else $error("input stage beat lost under stall");
`endif

endmodule

`default_nettype wire

// ===== tb/qef_energy_checker.sv =====
`timescale 1ns / 100ps

module qef_energy_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	input  wire                                 in_ready,
	input  wire logic signed [qef_pkg::X_W-1:0] sample,
	input  wire                                 restart,
	input  wire                                 out_valid,
	input  wire                                 out_ready,
	input  wire logic [qef_pkg::ENERGY_W-1:0]   energy,
	output int                                  mismatch_count,
	output int                                  energy_pending
);

	// filter state, kept as wide signed integers
	longint lp_hist [qef_pkg::LP_LEN];
	longint lp_y1;
	longint lp_y2;
	int     lp_pos;
	longint hp_hist [qef_pkg::HP_LEN];
	longint hp_sum;
	int     hp_pos;
	longint sl_hist [qef_pkg::SLOPE_LEN];
	int     sl_pos;
	longint win_hist [qef_pkg::WIN_LEN];
	longint win_sum;
	int     win_pos;

	// energy values owed by the block, oldest first
	logic [qef_pkg::ENERGY_W-1:0] energy_due [$];

	// zero every ring, sum and pointer
	function automatic void clear_filters();
		for (int i = 0; i < qef_pkg::LP_LEN; i++) lp_hist[i] = 0;
		for (int i = 0; i < qef_pkg::HP_LEN; i++) hp_hist[i] = 0;
		for (int i = 0; i < qef_pkg::SLOPE_LEN; i++) sl_hist[i] = 0;
		for (int i = 0; i < qef_pkg::WIN_LEN; i++) win_hist[i] = 0;
		lp_y1   = 0;
		lp_y2   = 0;
		lp_pos  = 0;
		hp_sum  = 0;
		hp_pos  = 0;
		sl_pos  = 0;
		win_sum = 0;
		win_pos = 0;
	endfunction

	// run one sample through the whole chain and return its energy
	function automatic logic [qef_pkg::ENERGY_W-1:0] predict_energy(input longint x);
		longint y;
		longint lp_out;
		longint z;
		longint d;
		longint avg;
		int     h;

		// recursive low-pass, scaled down by its dc gain
		h = (lp_pos + qef_pkg::LP_LEN - qef_pkg::LP_LEN / 2) % qef_pkg::LP_LEN;
		y = 2 * lp_y1 - lp_y2 + x - 2 * lp_hist[h] + lp_hist[lp_pos];
		lp_y2 = lp_y1;
		lp_y1 = y;
		lp_hist[lp_pos] = x;
		lp_pos = (lp_pos + 1) % qef_pkg::LP_LEN;
		lp_out = y / longint'(qef_pkg::LP_DIV);

		// delayed sample minus running mean
		hp_sum += lp_out - hp_hist[hp_pos];
		h = (hp_pos + qef_pkg::HP_LEN - qef_pkg::HP_LEN / 2) % qef_pkg::HP_LEN;
		z = hp_hist[h] - hp_sum / longint'(qef_pkg::HP_LEN);
		hp_hist[hp_pos] = lp_out;
		hp_pos = (hp_pos + 1) % qef_pkg::HP_LEN;

		// slope and magnitude
		d = z - sl_hist[sl_pos];
		sl_hist[sl_pos] = z;
		sl_pos = (sl_pos + 1) % qef_pkg::SLOPE_LEN;
		if (d < 0)
			d = -d;

		// moving-window integration with saturation
		win_sum += d - win_hist[win_pos];
		win_hist[win_pos] = d;
		win_pos = (win_pos + 1) % qef_pkg::WIN_LEN;
		avg = win_sum / longint'(qef_pkg::WIN_LEN);
		if (avg > qef_pkg::ENERGY_MAX)
			avg = qef_pkg::ENERGY_MAX;
		if (avg < 0)
			avg = 0;
		return avg[qef_pkg::ENERGY_W-1:0];
	endfunction

	// count a failure, print only the first few
	task automatic report_mismatch(input string what, input int expd, input int got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t qef_energy_checker: %s: expected %0d, got %0d",
				$realtime, what, expd, got);
	endtask

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		logic [qef_pkg::ENERGY_W-1:0] want;
		if (!arst_n) begin
			clear_filters();
			energy_due.delete();
			mismatch_count = 0;
			energy_pending = 0;
		end else begin
			// output beat against the oldest prediction
			if (out_valid && out_ready) begin
				if (energy_due.size() == 0) begin
					report_mismatch("energy beat with nothing owed", -1, int'(energy));
				end else begin
					want = energy_due.pop_front();
					if (energy !== want)
						report_mismatch("energy", int'(want), int'(energy));
				end
			end
			// input beat: restart clears before the sample is filtered
			if (in_valid && in_ready) begin
				if (restart)
					clear_filters();
				energy_due.push_back(predict_energy(longint'(sample)));
			end
			energy_pending = energy_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int STALL_LIMIT = 3000;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic signed [qef_pkg::X_W-1:0] sample    = '0;
	logic                           restart   = 1'b0;
	logic                           out_ready = 1'b0;
	wire                            in_ready;
	wire                            out_valid;
	wire   [qef_pkg::ENERGY_W-1:0]  energy;

	int mismatch_count;
	int energy_pending;
	int quiet_cycles = 0;
	bit calm         = 1'b0;
	bit steady_send  = 1'b0;
	bit hold_off_req = 1'b0;

	always #5 clk = ~clk;

	qrs_energy_filter_chain_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.energy    (energy)
	);

	qef_energy_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.energy         (energy),
		.mismatch_count (mismatch_count),
		.energy_pending (energy_pending)
	);

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		bit held_off;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req && !held_off) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				held_off = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// offer one sample and hold it until taken, then maybe idle
	task automatic send_beat(input logic signed [qef_pkg::X_W-1:0] s, input logic r);
		int n;
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (!calm && !steady_send && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// random waveform segments: noise, square waves, small noise, flat extremes
	task automatic run_stream(input int count);
		int                             sent;
		int                             mode;
		int                             seg_len;
		int                             period;
		int                             amp;
		logic signed [qef_pkg::X_W-1:0] s;
		logic signed [qef_pkg::X_W-1:0] level;
		sent = 0;
		while (sent < count) begin
			mode    = $urandom_range(0, 5);
			seg_len = $urandom_range(8, 80);
			period  = $urandom_range(2, 40);
			amp     = $urandom_range(0, 1) ? 32767 : $urandom_range(1, 32767);
			case ($urandom_range(0, 3))
				0: level = 16'sh7fff;
				1: level = -16'sh8000;
				2: level = '0;
				default: level = -16'sh1;
			endcase
			for (int i = 0; i < seg_len && sent < count; i++) begin
				case (mode)
					0: s = qef_pkg::X_W'($urandom);
					4: s = qef_pkg::X_W'($urandom_range(0, 64) - 32);
					5: s = level;
					default: s = ((i % period) < period / 2) ? qef_pkg::X_W'(amp)
						: qef_pkg::X_W'(-amp - 1);
				endcase
				send_beat(s, $urandom_range(0, 99) == 0);
				sent++;
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes and restart
		send_beat(16'sh7fff, 1'b0);
		send_beat(-16'sh8000, 1'b0);
		send_beat('0, 1'b0);
		send_beat(-16'sh1, 1'b0);
		send_beat(16'sh1, 1'b0);
		send_beat(16'sh5555, 1'b0);
		send_beat(-16'sh5556, 1'b0);
		send_beat(16'sh7fff, 1'b1);
		// full-scale square wave toward the saturation limit
		for (int i = 0; i < 15; i++)
			send_beat(((i / 5) % 2) ? -16'sh8000 : 16'sh7fff, 1'b0);
		send_beat(-16'sh8000, 1'b1);

		run_stream(500);

		// receiver holds off while samples keep coming, filling the pipe
		hold_off_req = 1'b1;
		steady_send  = 1'b1;
		run_stream(40);
		steady_send  = 1'b0;

		run_stream(300);

		// sender pause until everything has drained
		in_valid <= 1'b0;
		while (energy_pending != 0) @(negedge clk);

		calm = 1'b1;
		run_stream(360);
		in_valid <= 1'b0;

		while (energy_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (energy_pending != 0)
			$display("tb_top: %0d energy values never arrived", energy_pending);
		if (mismatch_count == 0 && energy_pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
